>>> design/layered_gate_envelope_assert.svh
// ----------------------------------------------------------------------------
// layered_gate_envelope assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LAYERED_GATE_ENVELOPE_ASSERT_SVH
`define LAYERED_GATE_ENVELOPE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LGE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// implication with a delayed consequent, sampled on clk, quiet during reset
`define LGE_ASSERT_DLY3(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##3 (cons)) else $error(msg);

`endif

>>> design/lge_pkg.sv
// ----------------------------------------------------------------------------
// lge_pkg
// Widths, register indexes, reset values and helpers for the envelope block.
// ----------------------------------------------------------------------------
package lge_pkg;

    localparam int TIME_BITS      = 32;
    localparam int FREQ_BITS      = 16;
    localparam int PHASE_BITS     = 16;
    localparam int PHASE_LSB      = 8;
    localparam int DUTY_BITS      = 17;
    localparam int ENABLE_BITS    = 4;
    localparam int FREQ_REG_BITS  = 64;
    localparam int AMP_REG_BITS   = 48;
    localparam int ENV_BITS       = 12;
    localparam int GATE_BITS      = 4;
    localparam int COUNT_BITS     = 3;
    localparam int SUM_BITS       = ENV_BITS + 2;   // at most four layers add up
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    localparam int DEF_LAYER_COUNT = 4;
    localparam int DEF_AMP_BITS    = 12;

    // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 2**SUM_BITS
    localparam int DIV3_MUL_BITS = 16;
    localparam logic [DIV3_MUL_BITS-1:0] DIV3_MUL = 16'd43691;
    localparam int DIV3_SHIFT = 17;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STACK_MODE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DUTY         = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE_MASK  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FREQUENCIES  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDES   = 3'd4;

    localparam logic [DUTY_BITS-1:0] DUTY_RESET = 17'd32768;

    // Low ENV_BITS of a lane's amplitude field; bits past the register read 0.
    function automatic logic [ENV_BITS-1:0] amp_field(
        input logic [AMP_REG_BITS-1:0] amps,
        input int                      lane,
        input int                      amp_bits
    );
        logic [ENV_BITS-1:0] r;
        int                  pos;
        r   = '0;
        pos = amp_bits * lane;
        for (int b = 0; b < ENV_BITS; b++)
        begin
            if (b < amp_bits && pos + b < AMP_REG_BITS)
            begin
                r[b] = amps[pos + b];
            end
        end
        return r;
    endfunction

endpackage

>>> design/lge_lane.sv
// ----------------------------------------------------------------------------
// lge_lane
// One layer's phase: time times frequency, fractional bits kept as Q0.16.
// ----------------------------------------------------------------------------
module lge_lane (
    input  logic                             clk,
    input  logic                             load,
    input  logic [lge_pkg::TIME_BITS-1:0]    time_value,
    input  logic [lge_pkg::FREQ_BITS-1:0]    freq,
    output logic [lge_pkg::PHASE_BITS-1:0]   phase
);
    import lge_pkg::*;

    localparam int PROD_BITS = TIME_BITS + FREQ_BITS;

    logic [PROD_BITS-1:0]  product;
    logic [PHASE_BITS-1:0] phase_reg;

    // Q16.16 * Q8.8 -> Q24.24; phase is fraction bits 23..8
    assign product = PROD_BITS'(time_value) * PROD_BITS'(freq);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            phase_reg <= product[PHASE_LSB +: PHASE_BITS];
        end
    end

    assign phase = phase_reg;

endmodule

>>> design/layered_gate_envelope.sv
// ----------------------------------------------------------------------------
// layered_gate_envelope
// Square-wave stimulus envelope built from up to four gated layers.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel: present time_value (Q16.16 s) with start high; the item is
//   taken on any rising edge where start is high and busy is low. busy is
//   high only while reset is applied and for the first cycle after it.
//   Result channel: done pulses for one cycle with envelope, gates_on and
//   enabled_layers. done rises once the item has passed the lane phase
//   registers, the stage-2 register and the output register; the receiver
//   cannot stall, so results flow out as they complete.
//   Throughput: one item per clock, set by the three-stage pipeline
//   (lane multipliers, gate/sum stage, averaging stage).
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   is always high. Indexes: 0 stack mode, 1 duty, 2 enable mask,
//   3 packed frequencies, 4 packed amplitudes; others are dropped.
//   Write config only while no item is in flight.
//   Reset: all pipeline valids cleared, duty back to one half, all other
//   config registers zero; pipeline data registers are not reset.
// ----------------------------------------------------------------------------
module layered_gate_envelope #(
    parameter int LAYER_COUNT = lge_pkg::DEF_LAYER_COUNT,
    parameter int AMP_BITS    = lge_pkg::DEF_AMP_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item in
    input  logic                                start,
    output logic                                busy,
    input  logic [lge_pkg::TIME_BITS-1:0]       time_value,
    // result out
    output logic                                done,
    output logic [lge_pkg::ENV_BITS-1:0]        envelope,
    output logic [lge_pkg::GATE_BITS-1:0]       gates_on,
    output logic [lge_pkg::COUNT_BITS-1:0]      enabled_layers,
    // config writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lge_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lge_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import lge_pkg::*;

    // stage 2 -> stage 3 bundle
    typedef struct packed {
        logic                  mode;
        logic [SUM_BITS-1:0]   sum;
        logic [ENV_BITS-1:0]   first;
        logic [COUNT_BITS-1:0] count;
        logic [GATE_BITS-1:0]  gates;
    } gate_sum_t;

    localparam int DIV3_PROD_BITS = SUM_BITS + DIV3_MUL_BITS;

    // ---------------- configuration registers ----------------
    logic                     mode_reg;
    logic [DUTY_BITS-1:0]     duty_reg;
    logic [ENABLE_BITS-1:0]   enable_reg;
    logic [FREQ_REG_BITS-1:0] freqs_reg;
    logic [AMP_REG_BITS-1:0]  amps_reg;
    logic                     cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            duty_reg   <= DUTY_RESET;
            enable_reg <= '0;
            freqs_reg  <= '0;
            amps_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_STACK_MODE:  mode_reg   <= cfg_data[0];
                REG_DUTY:        duty_reg   <= cfg_data[DUTY_BITS-1:0];
                REG_ENABLE_MASK: enable_reg <= cfg_data[ENABLE_BITS-1:0];
                REG_FREQUENCIES: freqs_reg  <= cfg_data[FREQ_REG_BITS-1:0];
                REG_AMPLITUDES:  amps_reg   <= cfg_data[AMP_REG_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // busy only covers the cycle right after reset release
    logic busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;

    logic accept;
    assign accept = start && !busy_reg;

    // ---------------- stage 1: per-lane phase ----------------
    logic                  s1_valid_reg;
    logic [PHASE_BITS-1:0] phase [LAYER_COUNT];
    logic [FREQ_BITS-1:0]  lane_freq [LAYER_COUNT];
    logic [LAYER_COUNT-1:0] lane_en;

    for (genvar i = 0; i < LAYER_COUNT; i++)
    begin : g_lane
        // layers past the packed registers read as disabled / zero
        if ((i + 1) * FREQ_BITS <= FREQ_REG_BITS)
        begin : g_freq
            assign lane_freq[i] = freqs_reg[i * FREQ_BITS +: FREQ_BITS];
        end
        else
        begin : g_no_freq
            assign lane_freq[i] = '0;
        end

        if (i < ENABLE_BITS)
        begin : g_en
            assign lane_en[i] = enable_reg[i];
        end
        else
        begin : g_no_en
            assign lane_en[i] = 1'b0;
        end

        lge_lane u_lane (
            .clk        (clk),
            .load       (accept),
            .time_value (time_value),
            .freq       (lane_freq[i]),
            .phase      (phase[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // ---------------- stage 2: gates, sum, first contributor ----------------
    logic [ENV_BITS-1:0] contrib [LAYER_COUNT];
    logic [LAYER_COUNT-1:0] lane_on;
    gate_sum_t s2_next;
    gate_sum_t s2_reg;
    logic      s2_valid_reg;

    always_comb
    begin
        s2_next       = '0;
        s2_next.mode  = mode_reg;
        for (int i = 0; i < LAYER_COUNT; i++)
        begin
            lane_on[i] = lane_en[i] && (DUTY_BITS'(phase[i]) < duty_reg);
            contrib[i] = lane_on[i] ? amp_field(amps_reg, i, AMP_BITS) : '0;
            s2_next.sum   = s2_next.sum + SUM_BITS'(contrib[i]);
            s2_next.count = s2_next.count + COUNT_BITS'(lane_en[i]);
            if (i < GATE_BITS)
            begin
                s2_next.gates[i] = lane_on[i];
            end
        end
        // lowest enabled layer wins: walk downward so it is written last
        for (int i = LAYER_COUNT - 1; i >= 0; i--)
        begin
            if (lane_en[i])
            begin
                s2_next.first = contrib[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // ---------------- stage 3: average and output register ----------------
    logic [DIV3_PROD_BITS-1:0] div3_prod;
    logic [SUM_BITS-1:0]       avg;
    logic [ENV_BITS-1:0]       env_next;

    logic                  done_reg;
    logic [ENV_BITS-1:0]   env_reg;
    logic [GATE_BITS-1:0]  gates_reg;
    logic [COUNT_BITS-1:0] count_reg;

    // count is 0..4: shifts, plus a reciprocal multiply for three
    assign div3_prod = DIV3_PROD_BITS'(s2_reg.sum) * DIV3_PROD_BITS'(DIV3_MUL);

    always_comb
    begin
        case (s2_reg.count)
            3'd1:    avg = s2_reg.sum;
            3'd2:    avg = s2_reg.sum >> 1;
            3'd3:    avg = SUM_BITS'(div3_prod[DIV3_PROD_BITS-1:DIV3_SHIFT]);
            3'd4:    avg = s2_reg.sum >> 2;
            default: avg = '0;
        endcase

        if (s2_reg.count == '0)
        begin
            env_next = '0;
        end
        else if (s2_reg.mode)
        begin
            env_next = avg[ENV_BITS-1:0];
        end
        else
        begin
            env_next = s2_reg.first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            env_reg   <= env_next;
            gates_reg <= s2_reg.gates;
            count_reg <= s2_reg.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    assign done           = done_reg;
    assign envelope       = env_reg;
    assign gates_on       = gates_reg;
    assign enabled_layers = count_reg;

    // ---------------- checks ----------------
    logic no_layers;
    assign no_layers = done && (enabled_layers == '0);

`include "layered_gate_envelope_assert.svh"

    `LGE_ASSERT_DLY3(a_latency, start && !busy, done, "result missing three cycles after item")
    `LGE_ASSERT_IMP(a_gates, done, $countones(gates_on) <= enabled_layers, "gates exceed layers")
    `LGE_ASSERT_IMP(a_idle_zero, no_layers, {envelope, gates_on} == '0, "output with no layers")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for layered_gate_envelope: drives time values through
// the command port, programs the five layer registers between item batches, and
// compares every envelope result against an in-bench prediction.
// ----------------------------------------------------------------------------

// One predicted or observed result.
typedef struct packed {
    logic [lge_pkg::ENV_BITS-1:0]   level;
    logic [lge_pkg::GATE_BITS-1:0]  gates;
    logic [lge_pkg::COUNT_BITS-1:0] layers;
} envelope_t;

// Shadow of the layer registers plus the queue of envelopes still owed.
class envelope_scoreboard;
    bit                                stacked;
    logic [lge_pkg::DUTY_BITS-1:0]     duty;
    logic [lge_pkg::ENABLE_BITS-1:0]   mask;
    logic [lge_pkg::FREQ_REG_BITS-1:0] freqs;
    logic [lge_pkg::AMP_REG_BITS-1:0]  amps;
    envelope_t                         owed[$];
    int                                errors;

    function new();
        stacked = 1'b0;
        duty    = lge_pkg::DUTY_RESET;
        mask    = '0;
        freqs   = '0;
        amps    = '0;
        errors  = 0;
    endfunction

    // Mirror a register write; unknown indexes are dropped, upper bits cut.
    function void write_reg(logic [lge_pkg::CFG_INDEX_BITS-1:0] idx,
                            logic [lge_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            lge_pkg::REG_STACK_MODE:  stacked = data[0];
            lge_pkg::REG_DUTY:        duty    = data[lge_pkg::DUTY_BITS-1:0];
            lge_pkg::REG_ENABLE_MASK: mask    = data[lge_pkg::ENABLE_BITS-1:0];
            lge_pkg::REG_FREQUENCIES: freqs   = data[lge_pkg::FREQ_REG_BITS-1:0];
            lge_pkg::REG_AMPLITUDES:  amps    = data[lge_pkg::AMP_REG_BITS-1:0];
            default: ;
        endcase
    endfunction

    // Gate each enabled layer on its phase, then pick first or average.
    function envelope_t expected_for(logic [lge_pkg::TIME_BITS-1:0] t);
        envelope_t                     r;
        logic [47:0]                   product;
        logic [lge_pkg::PHASE_BITS-1:0] phase;
        logic [lge_pkg::ENV_BITS-1:0]  amp;
        logic [lge_pkg::ENV_BITS-1:0]  first;
        logic [lge_pkg::SUM_BITS-1:0]  total;
        bit                            have_first;
        r          = '0;
        first      = '0;
        total      = '0;
        have_first = 1'b0;
        for (int k = 0; k < lge_pkg::DEF_LAYER_COUNT; k++)
        begin
            if (mask[k])
            begin
                r.layers = r.layers + 1'b1;
                product  = 48'(t) * 48'(freqs[16*k +: 16]);
                phase    = product[lge_pkg::PHASE_LSB +: lge_pkg::PHASE_BITS];
                amp      = '0;
                if ({1'b0, phase} < duty)
                begin
                    amp        = amps[lge_pkg::DEF_AMP_BITS*k +: lge_pkg::ENV_BITS];
                    r.gates[k] = 1'b1;
                end
                total = total + lge_pkg::SUM_BITS'(amp);
                if (!have_first)
                begin
                    first      = amp;
                    have_first = 1'b1;
                end
            end
        end
        if (r.layers == 0)
            r.level = '0;
        else if (!stacked)
            r.level = first;
        else
            r.level = lge_pkg::ENV_BITS'(total / lge_pkg::SUM_BITS'(r.layers));
        return r;
    endfunction

    function void note_time(logic [lge_pkg::TIME_BITS-1:0] t);
        owed.insert(owed.size(), expected_for(t));
    endfunction

    function void check_result(envelope_t got);
        envelope_t want;
        if (owed.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %h/%h/%h",
                     $time, got.level, got.gates, got.layers);
            return;
        end
        want = owed.pop_front();
        if (got.level !== want.level)
        begin
            errors++;
            $display("%0t: envelope expected %h actual %h", $time, want.level, got.level);
        end
        if (got.gates !== want.gates)
        begin
            errors++;
            $display("%0t: gates_on expected %h actual %h", $time, want.gates, got.gates);
        end
        if (got.layers !== want.layers)
        begin
            errors++;
            $display("%0t: enabled_layers expected %0d actual %0d",
                     $time, want.layers, got.layers);
        end
    endfunction
endclass

module tb_top;

    import lge_pkg::*;

    // watchdog limit, generous for the slowest run
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS_PER_PHASE = 300;
    localparam int ITEMS_PER_PROFILE = 50;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [TIME_BITS-1:0]      time_value = '0;
    logic                      done;
    logic [ENV_BITS-1:0]       envelope;
    logic [GATE_BITS-1:0]      gates_on;
    logic [COUNT_BITS-1:0]     enabled_layers;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    envelope_scoreboard sb = new();
    int                 cycles = 0;
    int                 idle_pct = 0;   // chance per cycle that the sender sits out

    layered_gate_envelope DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .time_value     (time_value),
        .done           (done),
        .envelope       (envelope),
        .gates_on       (gates_on),
        .enabled_layers (enabled_layers),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Monitor. Everything is sampled at the edge, before the edge's own
    // updates land, so the order of processes within the step is irrelevant.
    // Input is noted before the result check in case a result ever shows up
    // in the accepting cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_time(time_value);
            if (done)
                sb.check_result('{envelope, gates_on, enabled_layers});
        end
    end

    // One item: optional sender gap, then hold start until busy is low at
    // an edge. start stays high on return so back-to-back items never drop
    // it; only the gap path or the end lowers it.
    task automatic send_time(input logic [TIME_BITS-1:0] t);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        start      <= 1'b1;
        time_value <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Wait until the pipeline has handed back every item. The first edge lets
    // the monitor log an item accepted at the edge we returned from.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0)
            @(posedge clk);
    endtask

    // cfg_valid stays up across a burst; cfg_release drops it afterwards.
    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Full register set, finished with a write to an unmapped index that
    // must leave everything untouched.
    task automatic set_profile(input logic [63:0] stack_word,
                               input logic [63:0] duty_word,
                               input logic [63:0] mask_word,
                               input logic [63:0] freq_word,
                               input logic [63:0] amp_word);
        drain();
        cfg_write(REG_STACK_MODE, stack_word);
        cfg_write(REG_DUTY, duty_word);
        cfg_write(REG_ENABLE_MASK, mask_word);
        cfg_write(REG_FREQUENCIES, freq_word);
        cfg_write(REG_AMPLITUDES, amp_word);
        cfg_write(CFG_INDEX_BITS'(REG_AMPLITUDES + 1 + $urandom_range(0, 2)),
                  {$urandom, $urandom});
        cfg_release();
    endtask

    // Random register set, biased toward the duty and lane extremes.
    task automatic random_profile();
        logic [63:0] duty_word;
        logic [63:0] freq_word;
        logic [63:0] amp_word;
        case ($urandom_range(0, 5))
            0:       duty_word = '0;
            1:       duty_word = 64'd65536;
            2:       duty_word = {$urandom, $urandom} | 64'h1_FFFF;   // above one
            3:       duty_word = {$urandom, $urandom};                // junk high bits
            default: duty_word = 64'($urandom_range(0, 65536));
        endcase
        freq_word = {$urandom, $urandom};
        amp_word  = {$urandom, $urandom};
        for (int k = 0; k < DEF_LAYER_COUNT; k++)
        begin
            case ($urandom_range(0, 7))
                0: freq_word[16*k +: 16] = '0;
                1: freq_word[16*k +: 16] = 16'hFFFF;
                2: freq_word[16*k +: 16] = 16'($urandom_range(1, 16'h0400));
                default: ;
            endcase
            if ($urandom_range(0, 5) == 0)
                amp_word[DEF_AMP_BITS*k +: DEF_AMP_BITS] = '1;
        end
        set_profile({$urandom, $urandom}, duty_word, {$urandom, $urandom},
                    freq_word, amp_word);
    endtask

    // Time values: mostly full range, with the ends and short times mixed in.
    function automatic logic [TIME_BITS-1:0] random_time();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? '1 : '0;
            1:       return $urandom_range(0, 32'h0000_FFFF);
            2:       return $urandom_range(0, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---------------------------------------------------
        // nothing enabled straight out of reset
        send_time('0);
        send_time('1);

        // reset duty (one half) kept; zero frequency on layer 0 keeps it on,
        // layer 3 near the top of the frequency range
        drain();
        cfg_write(REG_ENABLE_MASK, 64'hF);
        cfg_write(REG_FREQUENCIES, {16'hFFFF, 16'h0180, 16'h0100, 16'h0000});
        cfg_write(REG_AMPLITUDES, {16'hFFFF, 12'hFFF, 12'h800, 12'h123, 12'hABC});
        cfg_release();
        send_time('0);
        send_time(32'h0000_8000);
        send_time(32'h0000_C000);
        send_time('1);

        // duty zero: every layer off
        set_profile(64'h1, 64'h0, 64'hF, {16'hFFFF, 16'h0180, 16'h0100, 16'h0000},
                    64'({12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}));
        send_time('0);
        send_time(32'h1234_5678);

        // duty exactly one, all amplitudes full: average is full scale
        set_profile(64'h1, 64'd65536, 64'hF, '1, '1);
        send_time('0);
        send_time('1);

        // duty above one with junk upper bits, three layers averaged
        set_profile('1, '1, 64'hFFFF_FFF0 | 64'hB, {16'h0001, 16'hFFFF, 16'h8000, 16'h0000},
                    64'({12'hFFF, 12'h001, 12'h7FF, 12'hFFE}));
        send_time('0);
        send_time(32'h8000_0001);
        send_time('1);

        // single mode whose first enabled layer is layer 2
        set_profile(64'h0, 64'h4000, 64'hC, {16'h0300, 16'h0080, 16'h0001, 16'h0000},
                    64'({12'h5A5, 12'hA5A, 12'hFFF, 12'hFFF}));
        send_time('0);
        send_time(32'h0000_4000);
        send_time(32'h0001_8000);
        send_time(32'hFFFF_0000);

        // stacked with nothing enabled
        set_profile(64'h1, 64'd65536, 64'h0, '1, '1);
        send_time('0);
        send_time('1);

        // --- random -----------------------------------------------------
        // sender idles 8 percent, then 76 percent, then never
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 8 : (ph == 1) ? 76 : 0;
            for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++)
            begin
                if (n % ITEMS_PER_PROFILE == 0)
                    random_profile();
                send_time(random_time());
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
